// File: sv/arb_pkg.sv
// Shared constants for the audio ring buffer with peak unit.
`default_nettype none

package arb_pkg;

    // Field widths
    localparam int ARB_RAW_W    = 32;
    localparam int ARB_SAMPLE_W = 24;
    localparam int ARB_OFFSET_W = 14;
    localparam int ARB_COUNT_W  = 7;
    localparam int ARB_CMD_W    = 2;

    // Default configuration
    localparam int ARB_RING_DEPTH  = 16384;
    localparam int ARB_PEAK_WINDOW = 256;
    localparam int ARB_MAX_BURST   = 64;

    // Command codes
    localparam logic [ARB_CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [ARB_CMD_W-1:0] CMD_PEAK = 2'd1;
    localparam logic [ARB_CMD_W-1:0] CMD_READ = 2'd2;

endpackage

`default_nettype wire

// File: sv/audio_ring_buffer_with_peak_unit.sv
// Audio capture ring with peak scan and read bursts, top level.
//
// Usage: present a command word with start high; it is taken at a rising
// edge where start is high and busy is low.
//   push (cmd 0): bits 23..0 of i_raw_word are stored at the write pointer,
//     which then advances with wrap-around. No result is given, and busy
//     stays low so pushes may come every cycle.
//   peak (cmd 1): the last PEAK_WINDOW samples are walked one per cycle
//     through a single magnitude/compare unit; busy stays high during the
//     scan, and the single result (o_is_peak, o_last) shows in the first
//     cycle with busy low again.
//   read (cmd 2): min(read_count, MAX_BURST) samples starting read_offset
//     entries behind the write pointer, one per cycle, through the store's
//     registered read and the result register; the final one has o_last.
//     A zero count gives no result and no busy time.
// The ring memory has one write and one registered read port; that port
// sets the one-sample-per-cycle pace of scans and bursts.
// Results are shown for one cycle under o_valid; the receiver cannot stall.
// Reset: the write pointer returns to zero and every entry reads as zero
// until first written (tracked by the pointer and a wrap flag, so there is
// no clearing pass and the block is usable right after reset).
`default_nettype none

module audio_ring_buffer_with_peak_unit
    import arb_pkg::*;
#(
    parameter int RING_DEPTH  = ARB_RING_DEPTH,
    parameter int PEAK_WINDOW = ARB_PEAK_WINDOW,
    parameter int MAX_BURST   = ARB_MAX_BURST
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire logic [ARB_CMD_W-1:0]           i_cmd,
    input  wire logic [ARB_RAW_W-1:0]           i_raw_word,
    input  wire logic [ARB_OFFSET_W-1:0]        i_read_offset,
    input  wire logic [ARB_COUNT_W-1:0]         i_read_count,
    output logic                                busy,
    output logic                                o_valid,
    output logic signed [ARB_SAMPLE_W-1:0]      o_sample_value,
    output logic [ARB_SAMPLE_W-1:0]             o_peak_value,
    output logic                                o_is_peak,
    output logic                                o_last
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(PEAK_WINDOW + 1);
    localparam int LW = (CW > ARB_COUNT_W) ? CW : ARB_COUNT_W;
    localparam logic [AW-1:0] PW_MOD = AW'(PEAK_WINDOW % RING_DEPTH);
    localparam logic [AW-1:0] WP_MAX = AW'(RING_DEPTH - 1);
    localparam logic [ARB_COUNT_W-1:0] BURST_MAX = ARB_COUNT_W'(MAX_BURST);
    localparam logic [LW-1:0] LEFT_ONE = LW'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PEAK = 3'b010,
        ST_READ = 3'b100
    } t_state;

    // Sample store
    logic [ARB_SAMPLE_W-1:0] mem [RING_DEPTH];
    logic [ARB_SAMPLE_W-1:0] r_rd_data;
    logic                    mem_we;
    logic                    mem_re;

    // Sequencer and pointers
    t_state          r_state, n_state;
    logic [AW-1:0]   r_wp, n_wp;
    logic            r_full, n_full;
    logic [AW-1:0]   r_addr, n_addr;
    logic [LW-1:0]   r_left, n_left;

    // Read-data stage tags
    logic            r_p1_vld, n_p1_vld;
    logic            r_p1_last, n_p1_last;
    logic            r_p1_peak, n_p1_peak;
    logic            r_p1_ok, n_p1_ok;

    // Peak accumulator and result register
    logic [ARB_SAMPLE_W-1:0] r_peak, n_peak;
    logic                    r_out_vld, n_out_vld;
    logic [ARB_SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic [ARB_SAMPLE_W-1:0] r_out_peak, n_out_peak;
    logic                    r_out_is_peak, n_out_is_peak;
    logic                    r_out_last, n_out_last;

    logic                    accept;
    logic [ARB_COUNT_W-1:0]  sat_count;
    logic [AW-1:0]           offs_w;
    logic [ARB_SAMPLE_W-1:0] s1_sample;
    logic [ARB_SAMPLE_W-1:0] s1_mag;
    logic [ARB_SAMPLE_W-1:0] s1_max;

    assign busy   = (r_state != ST_IDLE) || r_p1_vld;
    assign accept = start && !busy;

    assign sat_count = (i_read_count > BURST_MAX) ? BURST_MAX : i_read_count;
    assign offs_w    = AW'(i_read_offset);

    // Shared magnitude and compare unit on the read data
    assign s1_sample = r_p1_ok ? r_rd_data : '0;
    assign s1_mag    = s1_sample[ARB_SAMPLE_W-1] ? (~s1_sample + 1'b1) : s1_sample;
    assign s1_max    = (s1_mag > r_peak) ? s1_mag : r_peak;

    // Sequencer: one store access per cycle
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_full    = r_full;
        n_addr    = r_addr;
        n_left    = r_left;
        n_p1_vld  = 1'b0;
        n_p1_last = 1'b0;
        n_p1_peak = 1'b0;
        n_p1_ok   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_PUSH: begin
                            mem_we = 1'b1;
                            n_wp   = r_wp + 1'b1;
                            if (r_wp == WP_MAX) begin
                                n_full = 1'b1;
                            end
                        end
                        CMD_PEAK: begin
                            n_addr  = r_wp - PW_MOD;
                            n_left  = LW'(PEAK_WINDOW);
                            n_state = ST_PEAK;
                        end
                        CMD_READ: begin
                            if (sat_count != '0) begin
                                n_addr  = r_wp - offs_w;
                                n_left  = LW'(sat_count);
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PEAK, ST_READ: begin
                mem_re    = 1'b1;
                n_p1_vld  = 1'b1;
                n_p1_last = (r_left == LEFT_ONE);
                n_p1_peak = (r_state == ST_PEAK);
                // entries never written read as zero
                n_p1_ok   = r_full || (r_addr < r_wp);
                n_addr    = r_addr + 1'b1;
                n_left    = r_left - 1'b1;
                if (r_left == LEFT_ONE) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result stage
    always_comb begin
        n_peak        = r_peak;
        n_out_vld     = 1'b0;
        n_out_sample  = r_out_sample;
        n_out_peak    = r_out_peak;
        n_out_is_peak = r_out_is_peak;
        n_out_last    = r_out_last;
        if (accept && (i_cmd == CMD_PEAK)) begin
            n_peak = '0;
        end
        if (r_p1_vld) begin
            if (r_p1_peak) begin
                n_peak = s1_max;
                if (r_p1_last) begin
                    n_out_vld     = 1'b1;
                    n_out_sample  = '0;
                    n_out_peak    = s1_max;
                    n_out_is_peak = 1'b1;
                    n_out_last    = 1'b1;
                end
            end else begin
                n_out_vld     = 1'b1;
                n_out_sample  = s1_sample;
                n_out_peak    = '0;
                n_out_is_peak = 1'b0;
                n_out_last    = r_p1_last;
            end
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= i_raw_word[ARB_SAMPLE_W-1:0];
        end
        if (mem_re) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_full    <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_full    <= n_full;
            r_p1_vld  <= n_p1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr        <= n_addr;
        r_left        <= n_left;
        r_p1_last     <= n_p1_last;
        r_p1_peak     <= n_p1_peak;
        r_p1_ok       <= n_p1_ok;
        r_peak        <= n_peak;
        r_out_sample  <= n_out_sample;
        r_out_peak    <= n_out_peak;
        r_out_is_peak <= n_out_is_peak;
        r_out_last    <= n_out_last;
    end

    assign o_valid        = r_out_vld;
    assign o_sample_value = r_out_sample;
    assign o_peak_value   = r_out_peak;
    assign o_is_peak      = r_out_is_peak;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire
